// ----- rtl/fnv1a_hash_with_finalizer_defines.svh -----
// Assertion macros shared by the hash block.
// Used by the top level only; no other dependencies.
`ifndef FNV1A_HASH_WITH_FINALIZER_DEFINES_SVH
`define FNV1A_HASH_WITH_FINALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FNV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fnv assertion failed");

// Next-cycle implication, disabled during reset
`define FNV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fnv assertion failed");

`endif

// ----- rtl/fnv_pkg.sv -----
// Constants and shared types for the FNV-1a hash block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fnv_pkg;

   // FNV-1a and finalizer constants
   localparam logic [31:0] FNV_OFFSET_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME        = 32'h01000193;
   localparam logic [31:0] MIX_MUL_A        = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B        = 32'h846ca68b;

   // Hash queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Front to queue: one raw hash per finished message
   typedef struct packed {
      logic        valid;
      logic [31:0] data;
   } hash_push_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic        full;
      logic        not_empty;
      logic [31:0] head;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- rtl/fnv_front.sv -----
// Front end: takes message bytes, keeps the running FNV-1a state and
// pushes the raw hash of each finished message. Depends on fnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnv_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_wdata,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      req_tlast,
   input  wire fnv_pkg::queue_status_type q_status,
   output      fnv_pkg::hash_push_type    q_push
);

   logic        sign_ext_ff;
   logic        sign_ext_in;
   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] operand;
   logic [31:0] hash_upd;
   logic        xfer;

   // Stall the byte input while the queue has no room
   assign req_tready = !q_status.full;
   assign xfer       = req_tvalid && req_tready;

   // Byte operand, optionally sign extended
   always_comb begin
      if (sign_ext_ff && req_tdata[7]) begin
         operand = {24'hffffff, req_tdata};
      end else begin
         operand = {24'h000000, req_tdata};
      end
   end

   // One FNV-1a round when req_tuser is set; otherwise the state is kept
   always_comb begin
      if (req_tuser) begin
         hash_upd = (hash_ff ^ operand) * fnv_pkg::FNV_PRIME;
      end else begin
         hash_upd = hash_ff;
      end
   end

   // Next state
   always_comb begin
      sign_ext_in = csr_we ? csr_wdata : sign_ext_ff;
      hash_in     = hash_ff;
      if (xfer) begin
         hash_in = req_tlast ? fnv_pkg::FNV_OFFSET_BASIS : hash_upd;
      end
   end

   assign q_push.valid = xfer && req_tlast;
   assign q_push.data  = hash_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ext_ff <= 1'b0;
         hash_ff     <= fnv_pkg::FNV_OFFSET_BASIS;
      end else begin
         sign_ext_ff <= sign_ext_in;
         hash_ff     <= hash_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fnv_queue.sv -----
// Short queue of raw hashes between front and back.
// Depends on fnv_pkg for depth and interface types.
`timescale 1ns / 1ps
`default_nettype none

module fnv_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fnv_pkg::hash_push_type    q_push,
   input  wire logic                      q_pop,
   output      fnv_pkg::queue_status_type q_status
);

   localparam logic [fnv_pkg::QPTR_W-1:0] LAST_SLOT =
      fnv_pkg::QPTR_W'(fnv_pkg::QUEUE_DEPTH - 1);
   localparam logic [fnv_pkg::QCNT_W-1:0] FULL_COUNT =
      fnv_pkg::QCNT_W'(fnv_pkg::QUEUE_DEPTH);

   logic [31:0]                entry_ff [fnv_pkg::QUEUE_DEPTH];
   logic [fnv_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [fnv_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [fnv_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [fnv_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [fnv_pkg::QCNT_W-1:0] count_ff;
   logic [fnv_pkg::QCNT_W-1:0] count_in;

   assign q_status.full      = (count_ff == FULL_COUNT);
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.head      = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.valid && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push.valid && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fnv_back.sv -----
// Back end: lowbias32 finalizer as a three-step sequencer with an
// output register. Depends on fnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnv_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fnv_pkg::queue_status_type q_status,
   output      logic                      q_pop,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [31:0]               rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX2,
      ST_FIN
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   logic [31:0] mix_ff;
   logic [31:0] mix_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_data_ff;
   logic [31:0] out_data_in;
   logic        out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == ST_IDLE) && q_status.not_empty;

   // Sequencer: one xorshift and at most one multiply per step
   always_comb begin
      state_in     = state_ff;
      mix_in       = mix_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               mix_in   = (q_status.head ^ (q_status.head >> 16)) * fnv_pkg::MIX_MUL_A;
               state_in = ST_MIX2;
            end
         end
         ST_MIX2: begin
            mix_in   = (mix_ff ^ (mix_ff >> 15)) * fnv_pkg::MIX_MUL_B;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               out_data_in  = mix_ff ^ (mix_ff >> 16);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mix_ff      <= mix_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// ----- rtl/fnv1a_hash_with_finalizer.sv -----
// Top level of the FNV-1a hash with lowbias32 finalizer.
// Depends on fnv_pkg, fnv_front, fnv_queue, fnv_back and the defines header.
//
//   Channel  Dir  Payload                               Ends on
//   req      in   tdata data_byte, tuser has_byte       tlast = last_byte
//   rsp      out  tdata hash_value                      one per message
//   csr      in   csr_wdata sign_extend_bytes           csr_we
//
// Bytes are taken one per cycle unless stalled; the FNV round is one
// constant multiply. The finalizer steps ST_IDLE, ST_MIX2, ST_FIN per
// message, pops a new hash only in ST_IDLE, holds ST_FIN until rsp is free.
// A 2-entry hash queue lets the front keep running while the finalizer or
// the output stalls; req_tready drops only while that queue is full.
// Reset is synchronous: state returns to the offset basis, sign bit to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "fnv1a_hash_with_finalizer_defines.svh"

module fnv1a_hash_with_finalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,    // sign_extend_bytes
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tuser,    // [0] has_byte
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata     // [31:0] hash_value
);

   fnv_pkg::hash_push_type    q_push;
   fnv_pkg::queue_status_type q_status;
   logic                      q_pop;

   fnv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .q_push     (q_push)
   );

   fnv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   fnv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // No hash is pushed into a full queue
   `FNV_ASSERT_SAME(a_no_overflow, clock, reset, q_status.full, !q_push.valid)
   // The finalizer only pops a queue that holds a hash
   `FNV_ASSERT_SAME(a_no_underflow, clock, reset, q_pop, q_status.not_empty)
   // A pop from the queue with no push leaves room on the next cycle
   `FNV_ASSERT_NEXT(a_pop_frees, clock, reset, q_pop && !q_push.valid, !q_status.full)

endmodule

`default_nettype wire
